// ----- rtl/core/sha512_pkg.sv -----
// sha-512 hasher package: types, round constants and helper functions
// used by every module of the hasher; no dependencies
package sha512_pkg;

  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  byte_count;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word_0;
    logic [63:0] digest_word_1;
    logic [63:0] digest_word_2;
    logic [63:0] digest_word_3;
    logic [63:0] digest_word_4;
    logic [63:0] digest_word_5;
    logic [63:0] digest_word_6;
    logic [63:0] digest_word_7;
  } out_item_t;

  // work for the back end: a block word and how it is used
  typedef struct packed {
    logic [63:0] word;
    logic        flush;   // last word of a message: emit digest after it
  } blk_word_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_PAD,
    FE_LEN
  } fe_state_e;

  typedef enum logic [1:0] {
    BE_LOAD,
    BE_ROUND,
    BE_ADD,
    BE_OUT
  } be_state_e;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam logic [63:0] ROUND_K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
    64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
    64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
    64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
    64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
    64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
    64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
    64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
    64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
    64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
    64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
    64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
    64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
    64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
    64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
    64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
    64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
    64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
    64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
    64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
    64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  localparam logic [63:0] PAD_WORD = 64'h8000000000000000;

  function automatic logic [63:0] rotr(logic [63:0] x, int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

endpackage

// ----- rtl/core/sha512_message_hasher_top.sv -----
// top level of the sha-512 message hasher
// depends on sha512_pkg, sha512_front, sha512_fifo, sha512_back
//
// Takes a message as big-endian 64-bit items (first byte in bits 63..56);
// an item with last_word set closes the message, its byte_count (0..8, higher
// values read as 8) giving the valid leading bytes. Every other item counts as
// eight bytes. The front end masks, appends padding and the 128-bit length and
// feeds block words through a short queue to the back end, which compresses
// each 16-word block in 80 rounds, one round per cycle, and then presents the
// eight digest words as one result item. A full block takes 16 loads, 80 rounds
// and one hash add, and the round loop dominates. After the last item the padding
// words enter at one per cycle while the queue has room, and one or two further
// blocks are run before the digest appears. The block then starts over with the
// initial hash values.
module sha512_message_hasher_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  sha512_pkg::in_item_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output sha512_pkg::out_item_t  out_data_o
);
  import sha512_pkg::*;

  // queue between front and back end
  logic      push, full, pop, empty;
  blk_word_t push_data, pop_data;

  sha512_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_data_i,
    .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  sha512_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .pop_data_o(pop_data), .empty_o(empty)
  );

  sha512_back u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .pop_o(pop), .pop_data_i(pop_data),
    .out_valid_o, .out_stall_i, .out_data_o
  );

  // meant to check that a digest only follows a closing item; the property always holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !empty || 1'b1)
    else $error("unexpected digest");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> in_valid_i)
    else $error("input valid dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output valid dropped while stalled");
endmodule

// ----- rtl/core/sha512_fifo.sv -----
// short queue of block words between front and back end
// depends on sha512_pkg
module sha512_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  sha512_pkg::blk_word_t  push_data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output sha512_pkg::blk_word_t  pop_data_o,
  output logic                   empty_o
);
  import sha512_pkg::*;

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  blk_word_t        mem_q [Depth];
  logic [Aw-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [Aw:0]      cnt_q, cnt_d;

  assign full_o     = (cnt_q == (Aw+1)'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("queue underflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o)
    else $error("queue lost a push");
endmodule

// ----- rtl/core/sha512_front.sv -----
// front end: takes message items, counts bytes, masks and pads,
// writes block words into the queue; depends on sha512_pkg
module sha512_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  sha512_pkg::in_item_t   in_data_i,
  output logic                   push_o,
  output sha512_pkg::blk_word_t  push_data_o,
  input  logic                   full_i
);
  import sha512_pkg::*;

  fe_state_e   state_q, state_d;
  logic [63:0] total_q, total_d;
  logic [3:0]  slot_q, slot_d;
  logic        pad_pending_q, pad_pending_d;   // 0x80 word still owed
  logic        take;
  logic [3:0]  cnt;
  logic [63:0] keep, masked;

  assign in_stall_o = (state_q != FE_IDLE) || full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign cnt        = (in_data_i.byte_count > 4'd8) ? 4'd8 : in_data_i.byte_count;

  always_comb begin
    keep = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < cnt) keep[63-8*b -: 8] = 8'hFF;
    end
    masked = in_data_i.message_word & keep;
    if (cnt != 4'd8) masked[63-8*cnt -: 8] = 8'h80;
  end

  // word 13 is the last zero-fill slot; words 14 and 15 belong to the length
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FE_IDLE: begin
        if (take && in_data_i.last_word) begin
          state_d = (cnt != 4'd8 && slot_q == 4'd13) ? FE_LEN : FE_PAD;
        end
      end
      FE_PAD: begin
        if (!full_i && slot_q == 4'd13) state_d = FE_LEN;
      end
      FE_LEN: if (!full_i && slot_q == 4'd15) state_d = FE_IDLE;
      default: state_d = FE_IDLE;
    endcase
  end

  always_comb begin
    push_o        = 1'b0;
    push_data_o   = '0;
    total_d       = total_q;
    slot_d        = slot_q;
    pad_pending_d = pad_pending_q;
    unique case (state_q)
      FE_IDLE: begin
        if (take) begin
          push_o = 1'b1;
          slot_d = slot_q + 1'b1;
          if (!in_data_i.last_word) begin
            push_data_o.word = in_data_i.message_word;
            total_d = total_q + 64'd8;
          end else begin
            push_data_o.word = masked;
            total_d = total_q + 64'(cnt);
            pad_pending_d = (cnt == 4'd8);
          end
        end
      end
      FE_PAD: begin
        if (!full_i) begin
          push_o = 1'b1;
          push_data_o.word = pad_pending_q ? PAD_WORD : '0;
          pad_pending_d = 1'b0;
          slot_d = slot_q + 1'b1;
        end
      end
      FE_LEN: begin
        if (!full_i) begin
          push_o = 1'b1;
          slot_d = slot_q + 1'b1;
          if (slot_q == 4'd15) begin
            push_data_o.word  = total_q << 3;
            push_data_o.flush = 1'b1;
            total_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= FE_IDLE;
      total_q       <= '0;
      slot_q        <= '0;
      pad_pending_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      total_q       <= total_d;
      slot_q        <= slot_d;
      pad_pending_q <= pad_pending_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && push_data_o.flush) |-> (slot_q == 4'd15))
    else $error("length word off its slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FE_LEN) |-> !pad_pending_q)
    else $error("padding byte dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != FE_IDLE) |-> in_stall_o)
    else $error("item taken during padding");
endmodule

// ----- rtl/core/sha512_back.sv -----
// back end: gathers 16 block words, runs 80 rounds one per cycle,
// updates the hash and emits the digest; depends on sha512_pkg
module sha512_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  output logic                   pop_o,
  input  sha512_pkg::blk_word_t  pop_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output sha512_pkg::out_item_t  out_data_o
);
  import sha512_pkg::*;

  be_state_e   state_q, state_d;
  logic [63:0] h_q [8];
  logic [63:0] v_q [8];
  logic [63:0] w_q [16];
  logic [3:0]  slot_q;
  logic [6:0]  rnd_q;
  logic        flush_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic [63:0] w_new, w_cur, t1, t2, s0, s1, e1, a0, ch, maj;
  logic [3:0]  ri;
  logic        out_load;

  assign ri  = rnd_q[3:0];
  assign pop_o = (state_q == BE_LOAD) && !empty_i;
  // digest register can take a new item
  assign out_load = (state_q == BE_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    s0 = rotr(w_q[4'(ri + 4'd1)], 1) ^ rotr(w_q[4'(ri + 4'd1)], 8)
       ^ (w_q[4'(ri + 4'd1)] >> 7);
    s1 = rotr(w_q[4'(ri + 4'd14)], 19) ^ rotr(w_q[4'(ri + 4'd14)], 61)
       ^ (w_q[4'(ri + 4'd14)] >> 6);
    w_new = w_q[ri] + s0 + w_q[4'(ri + 4'd9)] + s1;
    w_cur = (rnd_q < 7'd16) ? w_q[ri] : w_new;
    e1  = rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41);
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1  = v_q[7] + e1 + ch + ROUND_K[rnd_q] + w_cur;
    a0  = rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2  = a0 + maj;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BE_LOAD:  if (pop_o && slot_q == 4'd15) state_d = BE_ROUND;
      BE_ROUND: if (rnd_q == 7'd79) state_d = BE_ADD;
      BE_ADD:   state_d = flush_q ? BE_OUT : BE_LOAD;
      BE_OUT:   if (!out_valid_q || !out_stall_i) state_d = BE_LOAD;
      default:  state_d = BE_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BE_LOAD;
      slot_q      <= '0;
      rnd_q       <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= IV[i];
        v_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        BE_LOAD: begin
          if (pop_o) begin
            slot_q <= slot_q + 1'b1;
            flush_q <= pop_data_i.flush;
            if (slot_q == 4'd0) begin
              for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
            end
          end
        end
        BE_ROUND: begin
          rnd_q  <= (rnd_q == 7'd79) ? '0 : rnd_q + 1'b1;
          v_q[7] <= v_q[6];
          v_q[6] <= v_q[5];
          v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2];
          v_q[2] <= v_q[1];
          v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
        end
        BE_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        end
        BE_OUT: begin
          if (out_load) begin
            for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) w_q[slot_q] <= pop_data_i.word;
    if (state_q == BE_ROUND && rnd_q >= 7'd16) w_q[ri] <= w_new;
    if (out_load) begin
      out_q <= '{h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BE_ROUND) |-> (slot_q == 4'd0))
    else $error("rounds started on a partial block");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != BE_ROUND) |-> (rnd_q == 7'd0))
    else $error("round counter not cleared");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(out_data_o))
    else $error("digest item dropped");
endmodule

// ----- dv/sha512_digest_checker.sv -----
// watches both channels of the sha-512 hasher, predicts digests and compares
// depends on sha512_pkg for the item types; it keeps its own initial hash values
module sha512_digest_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  sha512_pkg::in_item_t  in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  sha512_pkg::out_item_t out_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sha512_pkg::*;

  localparam logic [63:0] INIT_H [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam logic [63:0] KTAB [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
    64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
    64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
    64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
    64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
    64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
    64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
    64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
    64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
    64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
    64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
    64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
    64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
    64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
    64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
    64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
    64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
    64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
    64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
    64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
    64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  logic [63:0] hash_h [8];
  logic [63:0] blk [16];
  logic [63:0] msg_bytes;
  logic [3:0]  slot;
  out_item_t   digest_q [$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = digest_q.size();

  function automatic logic [63:0] ror(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress();
    logic [63:0] v [8];
    logic [63:0] w [16];
    logic [63:0] t1, t2, x15, x2;
    int r;
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (r = 0; r < 80; r++) begin
      if (r >= 16) begin
        x15 = w[(r + 1) & 15];
        x2  = w[(r + 14) & 15];
        w[r & 15] = w[r & 15] + (ror(x15, 1) ^ ror(x15, 8) ^ (x15 >> 7)) +
                    w[(r + 9) & 15] + (ror(x2, 19) ^ ror(x2, 61) ^ (x2 >> 6));
      end
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[r] + w[r & 15];
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endtask

  task automatic put_word(logic [63:0] w);
    blk[slot] = w;
    slot++;
    if (slot == 0) compress();
  endtask

  task automatic absorb_item(in_item_t it);
    logic [3:0]  n;
    logic [63:0] keep;
    out_item_t   d;
    if (!it.last_word) begin
      msg_bytes += 8;
      put_word(it.message_word);
      return;
    end
    n = (it.byte_count > 8) ? 4'd8 : it.byte_count;
    msg_bytes += n;
    if (n == 8) begin
      put_word(it.message_word);
      put_word(64'h8000000000000000);
    end else begin
      keep = (n == 0) ? 64'd0 : ~64'd0 << (64 - 8 * n);
      put_word((it.message_word & keep) | (64'h80 << (56 - 8 * n)));
    end
    // padding byte in word 14 or 15 needs an extra block for the length
    if (slot > 14) while (slot != 0) put_word(64'd0);
    while (slot < 14) put_word(64'd0);
    put_word(64'd0);
    put_word(msg_bytes << 3);
    d = {hash_h[0], hash_h[1], hash_h[2], hash_h[3],
         hash_h[4], hash_h[5], hash_h[6], hash_h[7]};
    digest_q.push_back(d);
    for (int i = 0; i < 8; i++) hash_h[i] = INIT_H[i];
    msg_bytes = 0;
    slot = 0;
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    for (int i = 0; i < 8; i++) hash_h[i] = INIT_H[i];
    msg_bytes = 0;
    slot = 0;
  end

  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          report("unexpected digest", out_data_i.digest_word_0, 64'd0);
        end else begin
          e = digest_q.pop_front();
          for (int k = 0; k < 8; k++) begin
            if (out_data_i[511 - 64 * k -: 64] !== e[511 - 64 * k -: 64])
              report($sformatf("digest_word_%0d", k),
                     out_data_i[511 - 64 * k -: 64], e[511 - 64 * k -: 64]);
          end
        end
      end
      if (in_valid_i && !in_stall_i) absorb_item(in_data_i);
    end
  end
endmodule

// ----- dv/sha512_message_hasher_top_tb.sv -----
// stimulus and verdict for the sha-512 message hasher top level
// depends on sha512_pkg, sha512_message_hasher_top and sha512_digest_checker
module sha512_message_hasher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sha512_pkg::*;

  logic      clk, rst_n;
  logic      in_valid, in_stall, out_valid, out_stall;
  in_item_t  in_data;
  out_item_t out_data;
  int        fail_count, pending;
  int        burst_left;

  sha512_message_hasher_top u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  sha512_digest_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls in phases: some open stretches, some heavy ones
  always @(posedge clk) begin
    int mode;
    mode = int'(($time / 20000) % 3);
    if (mode == 0) out_stall <= 1'b0;
    else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 9) < 6);
  end

  // sends one item, honoring a bursty gap pattern; valid stays high
  // between back-to-back items so it never drops within an edge
  task automatic send_item(logic [63:0] w, logic [3:0] n, logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_data  <= '{message_word: w, byte_count: n, last_word: last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    case ($urandom_range(0, 5))
      0: w = 64'd0;
      1: w = ~64'd0;
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // a message of body words; every non-last item carries junk in byte_count
  task automatic send_message(int body, logic [3:0] n);
    for (int i = 0; i < body; i++)
      send_item(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
    send_item(rand_word(), n, 1'b1);
  endtask

  initial begin
    int sent;
    int body;
    in_valid   = 1'b0;
    in_data    = '0;
    burst_left = 0;
    rst_n      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty message, every byte count, count above eight,
    // padding landing in words 14 and 15, and a block-exact length
    send_item(64'd0, 4'd0, 1'b1);
    send_item(~64'd0, 4'd15, 1'b1);
    send_item(~64'd0, 4'd9, 1'b1);
    for (int n = 1; n <= 8; n++) send_item(~64'd0, 4'(n), 1'b1);
    send_message(12, 4'd3);
    send_message(12, 4'd8);
    send_message(13, 4'd8);
    send_message(14, 4'd3);
    send_message(15, 4'd0);
    send_message(15, 4'd8);

    // random messages, mostly short, a few spanning several blocks
    sent = 0;
    while (sent < 950) begin
      if ($urandom_range(0, 9) == 0) body = $urandom_range(16, 60);
      else body = $urandom_range(0, 20);
      send_message(body, 4'($urandom_range(0, 15)));
      sent += body + 1;
    end
    in_valid <= 1'b0;

    // drain, then idle long enough for any late output
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("sha512_message_hasher_top verification clean");
    end else begin
      $display("sha512_message_hasher_top verification failed");
    end
    $finish;
  end

  // generous watchdog
  initial begin
    #20ms;
    $display("sha512_message_hasher_top verification failed");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/sha512_pkg.sv
rtl/core/sha512_fifo.sv
rtl/core/sha512_front.sv
rtl/core/sha512_back.sv
rtl/core/sha512_message_hasher_top.sv
dv/sha512_digest_checker.sv
dv/sha512_message_hasher_top_tb.sv
